@@ hdl/npt_pkg.sv @@
// Package for the node progress table.
// Holds the item, result and table entry types, command and status codes,
// and the controller state encoding. No dependencies.
package npt_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int CFG_W           = 5;
  localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;
  localparam int NODE_W          = 16;
  localparam int POS_W           = 64;
  localparam int IDX_W           = 4;
  localparam int IN_DATA_W       = 152;
  localparam int OUT_DATA_W      = 152;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_DROP    = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_NODE  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RDWAIT,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_id;
    logic [POS_W-1:0]  remote_position;
    logic [POS_W-1:0]  local_position;
    logic [IDX_W-1:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [POS_W-1:0]  remote_position;
    logic [POS_W-1:0]  local_position;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [IDX_W-1:0]  slot_used;
    logic [NODE_W-1:0] entry_node;
    logic [POS_W-1:0]  entry_remote;
    logic [POS_W-1:0]  entry_local;
  } result_t;

endpackage

@@ hdl/npt_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module npt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/npt_ctrl.sv @@
// Controller of the node progress table: command decode, pipelined slot scan,
// read-modify-write of the entry RAM and per-slot valid bits.
// Depends on npt_pkg.
module npt_ctrl #(
  parameter int TABLE_SLOTS = npt_pkg::DEF_TABLE_SLOTS,
  localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [npt_pkg::CFG_W-1:0]  slots_in_use,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  npt_pkg::item_t             in_item,
  output logic                       res_valid,
  input  logic                       res_ready,
  output npt_pkg::result_t           res,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output npt_pkg::entry_t            ram_wdata,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  npt_pkg::entry_t            ram_rdata
);

  npt_pkg::state_t  state, state_next;
  npt_pkg::item_t   item;
  logic [CNT_W-1:0] usable, usable_next;
  logic [CNT_W-1:0] rd_cnt;
  logic             chk_vld;
  logic [ADDR_W-1:0] chk_addr;
  logic             rvalid_bit;
  logic [TABLE_SLOTS-1:0] valid;
  logic             have_free;
  logic [ADDR_W-1:0] free_at;
  logic             hit;
  logic [ADDR_W-1:0] hit_at;
  npt_pkg::entry_t  hit_entry;

  npt_pkg::entry_t  cur;
  logic             rd_issue;
  logic             scan_hit;
  logic             free_seen;
  logic             start_err;
  npt_pkg::status_t start_status;
  logic             res_load;
  npt_pkg::result_t res_next;
  logic             set_vld;
  logic             clr_vld;
  logic [ADDR_W-1:0] vld_addr;

  function automatic logic [npt_pkg::IDX_W-1:0] IDX_CAST(input logic [ADDR_W-1:0] a);
    return npt_pkg::IDX_W'(a);
  endfunction

  assign usable_next = (int'(slots_in_use) > TABLE_SLOTS) ? CNT_W'(TABLE_SLOTS)
                                                          : CNT_W'(slots_in_use);
  assign cur       = rvalid_bit ? ram_rdata : '0;
  assign scan_hit  = chk_vld && (cur.node_id == item.node_id);
  assign free_seen = chk_vld && (cur.node_id == '0);
  assign rd_issue  = (state == npt_pkg::S_SCAN) && (rd_cnt < usable) && !scan_hit;
  assign in_ready  = (state == npt_pkg::S_IDLE);
  assign res_valid = (state == npt_pkg::S_DONE);

  always_comb begin
    start_err    = 1'b0;
    start_status = npt_pkg::ST_OK;
    case (item.cmd)
      npt_pkg::CMD_ADVANCE, npt_pkg::CMD_DROP: begin
        if (item.node_id == '0) begin
          start_err    = 1'b1;
          start_status = npt_pkg::ST_BAD_NODE;
        end
      end
      npt_pkg::CMD_READ: begin
        if (32'(item.slot_index) >= 32'(usable)) begin
          start_err    = 1'b1;
          start_status = npt_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        start_err    = 1'b1;
        start_status = npt_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      npt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = npt_pkg::S_START;
        end
      end
      npt_pkg::S_START: begin
        if (start_err) begin
          state_next = npt_pkg::S_DONE;
        end else if (item.cmd == npt_pkg::CMD_READ) begin
          state_next = npt_pkg::S_RDWAIT;
        end else begin
          state_next = npt_pkg::S_SCAN;
        end
      end
      npt_pkg::S_RDWAIT: state_next = npt_pkg::S_DONE;
      npt_pkg::S_SCAN: begin
        if (scan_hit || ((rd_cnt == usable) && !chk_vld)) begin
          state_next = npt_pkg::S_APPLY;
        end
      end
      npt_pkg::S_APPLY: state_next = npt_pkg::S_DONE;
      npt_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = npt_pkg::S_IDLE;
        end
      end
      default: state_next = npt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    res_load  = 1'b0;
    res_next  = '0;
    set_vld   = 1'b0;
    clr_vld   = 1'b0;
    vld_addr  = '0;
    case (state)
      npt_pkg::S_START: begin
        ram_raddr = ADDR_W'(item.slot_index);
        if (start_err) begin
          res_load        = 1'b1;
          res_next.status = start_status;
        end
      end
      npt_pkg::S_RDWAIT: begin
        res_load              = 1'b1;
        res_next.status       = npt_pkg::ST_OK;
        res_next.slot_used    = item.slot_index;
        res_next.entry_node   = cur.node_id;
        res_next.entry_remote = cur.remote_position;
        res_next.entry_local  = cur.local_position;
      end
      npt_pkg::S_SCAN: begin
        ram_raddr = rd_cnt[ADDR_W-1:0];
      end
      npt_pkg::S_APPLY: begin
        res_load = 1'b1;
        if (item.cmd == npt_pkg::CMD_ADVANCE) begin
          if (hit || have_free) begin
            ram_we            = 1'b1;
            ram_waddr         = hit ? hit_at : free_at;
            ram_wdata.node_id = item.node_id;
            ram_wdata.remote_position =
              (hit && (hit_entry.remote_position > item.remote_position)) ?
              hit_entry.remote_position : item.remote_position;
            ram_wdata.local_position =
              (hit && (hit_entry.local_position > item.local_position)) ?
              hit_entry.local_position : item.local_position;
            set_vld               = 1'b1;
            vld_addr              = ram_waddr;
            res_next.status       = npt_pkg::ST_OK;
            res_next.found        = hit;
            res_next.slot_used    = IDX_CAST(ram_waddr);
            res_next.entry_node   = ram_wdata.node_id;
            res_next.entry_remote = ram_wdata.remote_position;
            res_next.entry_local  = ram_wdata.local_position;
          end else begin
            res_next.status = npt_pkg::ST_FULL;
          end
        end else begin
          res_next.status = npt_pkg::ST_OK;
          if (hit) begin
            clr_vld            = 1'b1;
            vld_addr           = hit_at;
            res_next.found     = 1'b1;
            res_next.slot_used = IDX_CAST(hit_at);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npt_pkg::S_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (set_vld) begin
        valid[vld_addr] <= 1'b1;
      end
      if (clr_vld) begin
        valid[vld_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rvalid_bit <= valid[ram_raddr];
    if (state == npt_pkg::S_IDLE && in_valid) begin
      item   <= in_item;
      usable <= usable_next;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (state == npt_pkg::S_START) begin
      rd_cnt    <= '0;
      chk_vld   <= 1'b0;
      have_free <= 1'b0;
      hit       <= 1'b0;
    end else if (state == npt_pkg::S_SCAN) begin
      if (rd_issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      chk_vld  <= rd_issue;
      chk_addr <= rd_cnt[ADDR_W-1:0];
      if (free_seen && !have_free) begin
        have_free <= 1'b1;
        free_at   <= chk_addr;
      end
      if (scan_hit) begin
        hit       <= 1'b1;
        hit_at    <= chk_addr;
        hit_entry <= cur;
      end
    end
  end

endmodule

@@ hdl/node_progress_table.sv @@
// Node progress table: per-node replay positions held in one entry RAM.
// An error is answered from the start state, a read after one registered RAM read, and an
// advance or drop after a scan that stops at the matching slot, else after all usable
// slots; the scan reads one RAM slot per cycle. One word is in work at a time; the next
// can be taken once the answer has been registered into the output.
// Reset clears all slots through per-slot valid bits at once and sets slots_in_use to 16.
module node_progress_table #(
  parameter int TABLE_SLOTS = npt_pkg::DEF_TABLE_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [npt_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // node_id, remote_position, local_position, slot_index, zero pad
  input  logic [npt_pkg::IN_DATA_W-1:0]   s_tdata,
  // cmd
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, found, slot_used, entry_node, entry_remote, entry_local, zero pad
  output logic [npt_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [npt_pkg::CFG_W-1:0] slots_in_use;
  npt_pkg::item_t   in_item;
  npt_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  npt_pkg::entry_t  ram_wdata;
  npt_pkg::entry_t  ram_rdata;
  logic [npt_pkg::ENTRY_W-1:0] ram_rbits;

  assign in_item.cmd             = s_tuser;
  assign in_item.node_id         = s_tdata[15:0];
  assign in_item.remote_position = s_tdata[79:16];
  assign in_item.local_position  = s_tdata[143:80];
  assign in_item.slot_index      = s_tdata[147:144];
  assign ram_rdata               = npt_pkg::entry_t'(ram_rbits);
  assign res_ready               = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= npt_pkg::SLOTS_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        slots_in_use <= cfg_wdata;
      end
      if (res_ready) begin
        m_tvalid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.entry_local, res.entry_remote, res.entry_node,
                  res.slot_used, res.found, res.status};
    end
  end

  npt_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .slots_in_use(slots_in_use),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  npt_ram #(
    .WIDTH(npt_pkg::ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

endmodule
